@@ src/gbs_pkg.sv @@
package gbs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH     = 7;
  localparam int CFG_IDX_WIDTH   = 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 7'd127;

  // search phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_GALLOP = 2'd1;
  localparam logic [1:0] PH_BISECT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_PROBE      = 2'd0;
  localparam logic [1:0] ST_FOUND      = 2'd1;
  localparam logic [1:0] ST_IMPOSSIBLE = 2'd2;
  localparam logic [1:0] ST_IGNORED    = 2'd3;

  // input function codes
  localparam logic FN_START  = 1'b0;
  localparam logic FN_ANSWER = 1'b1;

  // oracle answer codes
  localparam logic [1:0] ANS_GREATER = 2'd0;
  localparam logic [1:0] ANS_LESS    = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RANGE_LOW  = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RANGE_HIGH = 1'd1;

  typedef struct packed {
    logic [1:0]             phase;
    logic [COUNT_WIDTH-1:0] count;
  } gbs_ctl_t;

endpackage

@@ src/gbs_step.sv @@
module gbs_step #(
  parameter int VALUE_WIDTH = gbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   func_i,
  input  logic [1:0]             answer_i,
  input  gbs_pkg::gbs_ctl_t      ctl_i,
  input  logic [VALUE_WIDTH-1:0] lower_i,
  input  logic [VALUE_WIDTH-1:0] upper_i,
  input  logic [VALUE_WIDTH:0]   stride_i,
  input  logic [VALUE_WIDTH-1:0] probe_i,
  input  logic [VALUE_WIDTH-1:0] range_low_i,
  input  logic [VALUE_WIDTH-1:0] range_high_i,
  output gbs_pkg::gbs_ctl_t      ctl_o,
  output logic [VALUE_WIDTH-1:0] lower_o,
  output logic [VALUE_WIDTH-1:0] upper_o,
  output logic [VALUE_WIDTH:0]   stride_o,
  output logic [VALUE_WIDTH-1:0] probe_o,
  output logic [VALUE_WIDTH-1:0] query_value_o,
  output logic [1:0]             status_o
);

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]   first_probe;
  logic [W:0]     stride_dbl;
  logic [W+1:0]   gallop_sum;
  logic           gallop_below;
  logic [W-1:0]   gallop_probe;
  logic [W-1:0]   lb_b;
  logic [W-1:0]   ub_b;
  logic [W:0]     bound_diff;
  logic [W:0]     bound_sum;
  logic           adjacent;
  logic [W-1:0]   mid;
  logic [gbs_pkg::COUNT_WIDTH-1:0] count_inc;

  assign first_probe = (range_low_i == VAL_MAX) ? VAL_MAX : range_low_i + {{(W-1){1'b0}}, 1'b1};
  // stride is a power of two that sticks once it reaches 2^W
  assign stride_dbl  = stride_i[W] ? stride_i : {stride_i[W-1:0], 1'b0};
  assign gallop_sum  = {{2{range_low_i[W-1]}}, range_low_i} + {1'b0, stride_dbl};
  assign gallop_below = $signed(gallop_sum) < $signed({{2{range_high_i[W-1]}}, range_high_i});
  assign gallop_probe = gallop_below ? gallop_sum[W-1:0] : range_high_i;

  always_comb begin
    if (ctl_i.phase == gbs_pkg::PH_GALLOP) begin
      lb_b = lower_i;
      ub_b = probe_i;
    end else if (answer_i == gbs_pkg::ANS_GREATER) begin
      lb_b = probe_i;
      ub_b = upper_i;
    end else begin
      lb_b = lower_i;
      ub_b = probe_i;
    end
  end

  assign bound_diff = {lb_b[W-1], lb_b} - {ub_b[W-1], ub_b};
  assign bound_sum  = {lb_b[W-1], lb_b} + {ub_b[W-1], ub_b};
  assign adjacent   = (bound_diff == '0) || (bound_diff == {{W{1'b0}}, 1'b1})
                      || (bound_diff == '1);
  // arithmetic shift gives the floor midpoint
  assign mid        = bound_sum[W:1];
  assign count_inc  = (ctl_i.count == gbs_pkg::COUNT_MAX) ? ctl_i.count
                      : ctl_i.count + 1'b1;

  always_comb begin
    ctl_o         = ctl_i;
    lower_o       = lower_i;
    upper_o       = upper_i;
    stride_o      = stride_i;
    probe_o       = probe_i;
    query_value_o = '0;
    status_o      = gbs_pkg::ST_IGNORED;
    if (func_i == gbs_pkg::FN_START) begin
      lower_o       = range_low_i;
      upper_o       = range_high_i;
      stride_o      = {{W{1'b0}}, 1'b1};
      probe_o       = first_probe;
      ctl_o.count   = {{(gbs_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
      ctl_o.phase   = gbs_pkg::PH_GALLOP;
      query_value_o = first_probe;
      status_o      = gbs_pkg::ST_PROBE;
    end else if (ctl_i.phase != gbs_pkg::PH_GALLOP && ctl_i.phase != gbs_pkg::PH_BISECT) begin
      ctl_o.phase = gbs_pkg::PH_IDLE;
    end else if (answer_i[1]) begin
      // code three counts as in range too
      ctl_o.phase   = gbs_pkg::PH_IDLE;
      query_value_o = probe_i;
      status_o      = gbs_pkg::ST_FOUND;
    end else if (ctl_i.phase == gbs_pkg::PH_GALLOP && answer_i == gbs_pkg::ANS_GREATER) begin
      if (probe_i == range_high_i) begin
        ctl_o.phase = gbs_pkg::PH_IDLE;
        status_o    = gbs_pkg::ST_IMPOSSIBLE;
      end else begin
        lower_o       = probe_i;
        stride_o      = stride_dbl;
        probe_o       = gallop_probe;
        ctl_o.count   = count_inc;
        query_value_o = gallop_probe;
        status_o      = gbs_pkg::ST_PROBE;
      end
    end else begin
      lower_o     = lb_b;
      upper_o     = ub_b;
      ctl_o.phase = gbs_pkg::PH_BISECT;
      if (adjacent) begin
        ctl_o.phase = gbs_pkg::PH_IDLE;
        status_o    = gbs_pkg::ST_IMPOSSIBLE;
      end else begin
        probe_o       = mid;
        ctl_o.count   = count_inc;
        query_value_o = mid;
        status_o      = gbs_pkg::ST_PROBE;
      end
    end
  end

endmodule

@@ src/galloping_binary_search_controller.sv @@
// galloping search controller: drives an exponential-then-bisection search
// against an outside oracle, one result beat per input beat.
// input channel (in_valid_i / in_stall_o): func_i = start or answer,
// answer_i = oracle reply to the last probe.
// output channel (out_valid_o / out_stall_i): query_value_o, status_o
// (probing, found, impossible, ignored) and step_count_o.
// config channel (cfg_valid_i / cfg_ready_o): cfg_index_i selects
// range_low or range_high, cfg_data_i is the value; always ready, write
// only while no search beat is in flight.
// path: a beat taken into the input register passes the step logic and its
// result is registered in the output register, from which it is taken.
// throughput: one beat per cycle while out_stall_i is low; the search
// state does one add/compare/shift pass between input and output register.
// reset: no beats held, phase idle, bounds, stride, count and range zero.
// stall: while out_stall_i holds a result, one more input beat is taken
// into the input register, then in_stall_o rises until the output drains.
module galloping_binary_search_controller #(
  parameter int VALUE_WIDTH = gbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [1:0]                        answer_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [VALUE_WIDTH-1:0]            query_value_o,
  output logic [1:0]                        status_o,
  output logic [gbs_pkg::COUNT_WIDTH-1:0]   step_count_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbs_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]            cfg_data_i
);

  localparam int W = VALUE_WIDTH;

  logic              in_v_q;
  logic              func_q;
  logic [1:0]        answer_q;
  logic              out_v_q;
  logic [W-1:0]      value_q;
  logic [1:0]        status_q;
  logic [gbs_pkg::COUNT_WIDTH-1:0] count_out_q;

  gbs_pkg::gbs_ctl_t ctl_q, ctl_d;
  logic [W-1:0]      lower_q, lower_d;
  logic [W-1:0]      upper_q, upper_d;
  logic [W:0]        stride_q, stride_d;
  logic [W-1:0]      probe_q, probe_d;
  logic [W-1:0]      range_low_q;
  logic [W-1:0]      range_high_q;
  logic [W-1:0]      value_d;
  logic [1:0]        status_d;

  logic res_ready;
  logic advance;
  logic in_accept;

  assign res_ready  = !out_v_q || !out_stall_i;
  assign advance    = in_v_q && res_ready;
  assign in_stall_o = in_v_q && !res_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  gbs_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .func_i        (func_q),
    .answer_i      (answer_q),
    .ctl_i         (ctl_q),
    .lower_i       (lower_q),
    .upper_i       (upper_q),
    .stride_i      (stride_q),
    .probe_i       (probe_q),
    .range_low_i   (range_low_q),
    .range_high_i  (range_high_q),
    .ctl_o         (ctl_d),
    .lower_o       (lower_d),
    .upper_o       (upper_d),
    .stride_o      (stride_d),
    .probe_o       (probe_d),
    .query_value_o (value_d),
    .status_o      (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      ctl_q        <= '{phase: gbs_pkg::PH_IDLE, count: '0};
      lower_q      <= '0;
      upper_q      <= '0;
      stride_q     <= '0;
      probe_q      <= '0;
      range_low_q  <= '0;
      range_high_q <= '0;
    end else begin
      if (in_accept) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q  <= 1'b1;
        ctl_q    <= ctl_d;
        lower_q  <= lower_d;
        upper_q  <= upper_d;
        stride_q <= stride_d;
        probe_q  <= probe_d;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gbs_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data_i;
          gbs_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= func_i;
      answer_q <= answer_i;
    end
    if (advance) begin
      value_q     <= value_d;
      status_q    <= status_d;
      count_out_q <= ctl_d.count;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_v_q;
  assign query_value_o = value_q;
  assign status_o      = status_q;
  assign step_count_o  = count_out_q;

endmodule

@@ src/gbs_checker.sv @@
module gbs_checker #(
  parameter int VALUE_WIDTH = gbs_pkg::VALUE_WIDTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [VALUE_WIDTH-1:0]          query_value_o,
  input logic [1:0]                      status_o,
  input logic [gbs_pkg::COUNT_WIDTH-1:0] step_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(query_value_o)
      && $stable(status_o) && $stable(step_count_o))
    else $error("stalled result beat changed");

  a_impossible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gbs_pkg::ST_IMPOSSIBLE |-> query_value_o == '0)
    else $error("impossible result carries a value");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gbs_pkg::ST_IGNORED |-> query_value_o == '0)
    else $error("ignored result carries a value");

  a_probe_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gbs_pkg::ST_PROBE |-> step_count_o != '0)
    else $error("probe issued with zero step count");

endmodule

bind galloping_binary_search_controller gbs_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_gbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .query_value_o (query_value_o),
  .status_o      (status_o),
  .step_count_o  (step_count_o)
);
